@@ rtl/sobel_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared constants and types for the Sobel edge threshold block.
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = 10;
  localparam int ROW_W  = 12;
  localparam int WCFG_W = 11;
  localparam int HCFG_W = 13;
  localparam int CFG_W  = 13;
  localparam int WORD_W = 64;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2
  } reg_idx_t;

  // byte 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [3:0][7:0] pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } colv_t;

endpackage

`default_nettype wire

@@ rtl/sobel_edge_threshold.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// Streaming 3x3 Sobel edge test on RGBA pixels with a two-row line store.
// ----------------------------------------------------------------------------
// Each result passes the job stage, then s1, s2, s3 and the output register.
// Throughput: one pixel per cycle when the output is not stalled; a pixel that
//   causes n results (row end, last row) holds the input until its last result
//   is issued to the one-window-per-cycle gradient pipeline. The line store is
//   read and written once per pixel.
// Reset: counters clear, geometry 1024x1024, threshold 0; the line store is
//   not cleared and needs no clearing pass.
module sobel_edge_threshold (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [31:0]                 in_tdata,   // red, green, blue, alpha
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [31:0]                      out_tdata,  // is_edge, pixel_alpha,
                                                       // out_row, out_column, pad
  output logic                             out_tlast,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_addr,
  input  wire logic [sobel_pkg::CFG_W-1:0] cfg_wdata
);
  import sobel_pkg::*;

  localparam logic [WCFG_W-1:0] W_MAX = WCFG_W'(MAX_WIDTH);
  localparam logic [HCFG_W-1:0] H_MAX = HCFG_W'(MAX_HEIGHT);

  logic [WCFG_W-1:0] w_r, w_eff;
  logic [HCFG_W-1:0] h_r, h_eff;
  logic [15:0]       thr_sq_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;

  logic accept, last_col, last_row;

  // job stage
  logic              j_v_r;
  pix_t              j_pix_r;
  logic [ROW_W-1:0]  j_row_r;
  logic [COL_W-1:0]  j_col_r;
  logic              j_ha_r, j_hb_r, j_ca_r, j_cb_r;
  logic [1:0]        j_k_r, j_k_nxt;
  logic              j_fwd_r;
  logic [WORD_W-1:0] j_fwd_data_r;
  logic [WORD_W-1:0] rdata, mword, wword;
  logic              j_empty, j_last, j_retire, issue;
  colv_t             cur, w1_r, w2_r;
  logic              rsel, csel;

  // compute pipeline
  logic              s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic              s1_rdy, rdy1, rdy2, rdy3;
  colv_t             win_l, win_c, win_r;
  colv_t             s1_l_r, s1_c_r, s1_r_r;
  logic [7:0]        s1_a_r, s2_a_r, s3_a_r;
  logic [ROW_W-1:0]  s1_row_r, s2_row_r, s3_row_r;
  logic [COL_W-1:0]  s1_col_r, s2_col_r, s3_col_r;
  logic              s1_last_r, s2_last_r, s3_last_r;
  logic signed [10:0] gx [3], gy [3], s2_gx_r [3], s2_gy_r [3];
  logic [19:0]       sq [6], s3_sq_r [6];
  logic [22:0]       total;
  logic              o_edge_r, o_last_r;
  logic [7:0]        o_a_r;
  logic [ROW_W-1:0]  o_row_r;
  logic [COL_W-1:0]  o_col_r;

  function automatic colv_t pick_rows(colv_t v, logic sel, logic [ROW_W-1:0] r);
    colv_t o;
    if (!sel) begin
      o.top = (r == ROW_W'(1)) ? v.mid : v.top;
      o.mid = v.mid;
      o.bot = v.bot;
    end else begin
      o.top = (r != '0) ? v.mid : v.bot;
      o.mid = v.bot;
      o.bot = v.bot;
    end
    return o;
  endfunction

  assign w_eff = (w_r == '0) ? WCFG_W'(1) : ((w_r > W_MAX) ? W_MAX : w_r);
  assign h_eff = (h_r == '0) ? HCFG_W'(1) : ((h_r > H_MAX) ? H_MAX : h_r);
  assign last_col = ({1'b0, col_r} == w_eff - WCFG_W'(1));
  assign last_row = ({1'b0, row_r} == h_eff - HCFG_W'(1));

  // pipeline readiness
  assign rdy3   = !out_v_r || out_tready;
  assign rdy2   = !s3_v_r || rdy3;
  assign rdy1   = !s2_v_r || rdy2;
  assign s1_rdy = !s1_v_r || rdy1;

  assign j_empty  = !(j_ha_r || j_hb_r) || !(j_ca_r || j_cb_r);
  assign j_last   = (j_k_r[1] == (j_ha_r && j_hb_r)) && (j_k_r[0] == (j_ca_r && j_cb_r));
  assign issue    = j_v_r && !j_empty && s1_rdy;
  assign j_retire = j_v_r && (j_empty || (s1_rdy && j_last));
  assign in_tready = !j_v_r || j_retire;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    j_k_nxt = j_k_r;
    if (j_ca_r && j_cb_r && !j_k_r[0]) begin
      j_k_nxt[0] = 1'b1;
    end else begin
      j_k_nxt = {1'b1, 1'b0};
    end
  end

  // line store: low word row r-1, high word row r-2
  assign mword = j_fwd_r ? j_fwd_data_r : rdata;
  assign wword = {mword[31:0], j_pix_r};
  assign cur   = '{top: mword[63:32], mid: mword[31:0], bot: j_pix_r};

  sobel_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WIDTH)) u_store (
    .clk   (clk),
    .we    (j_retire),
    .waddr (j_col_r),
    .wdata (wword),
    .re    (accept),
    .raddr (col_r),
    .rdata (rdata)
  );

  // window selection for the current result
  always_comb begin
    colv_t cl, cc, cr;
    rsel = (j_ha_r && j_hb_r) ? j_k_r[1] : j_hb_r;
    csel = (j_ca_r && j_cb_r) ? j_k_r[0] : j_cb_r;
    if (!csel) begin
      cl = (j_col_r == COL_W'(1)) ? w1_r : w2_r;
      cc = w1_r;
      cr = cur;
    end else begin
      cl = (j_col_r != '0) ? w1_r : cur;
      cc = cur;
      cr = cur;
    end
    win_l = pick_rows(cl, rsel, j_row_r);
    win_c = pick_rows(cc, rsel, j_row_r);
    win_r = pick_rows(cr, rsel, j_row_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r      <= W_MAX;
      h_r      <= HCFG_W'(1024);
      thr_sq_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      j_v_r    <= 1'b0;
      j_k_r    <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (accept) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_addr))
          REG_WIDTH: begin
            w_r   <= cfg_wdata[WCFG_W-1:0];
            col_r <= '0;
            row_r <= '0;
          end
          REG_HEIGHT: begin
            h_r   <= cfg_wdata[HCFG_W-1:0];
            col_r <= '0;
            row_r <= '0;
          end
          REG_THRESH: thr_sq_r <= 16'(cfg_wdata[7:0]) * 16'(cfg_wdata[7:0]);
          default: ;
        endcase
      end
      if (accept) begin
        j_v_r <= 1'b1;
        j_k_r <= '0;
      end else if (j_retire) begin
        j_v_r <= 1'b0;
      end else if (issue) begin
        j_k_r <= j_k_nxt;
      end
      if (s1_rdy) s1_v_r <= issue;
      if (rdy1)   s2_v_r <= s1_v_r;
      if (rdy2)   s3_v_r <= s2_v_r;
      if (rdy3)   out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      j_pix_r      <= in_tdata;
      j_row_r      <= row_r;
      j_col_r      <= col_r;
      j_ha_r       <= (row_r != '0);
      j_hb_r       <= last_row;
      j_ca_r       <= (col_r != '0);
      j_cb_r       <= last_col;
      j_fwd_r      <= j_v_r && (j_col_r == col_r);
      j_fwd_data_r <= wword;
    end
    if (j_retire) begin
      w2_r <= w1_r;
      w1_r <= cur;
    end
  end

  // gradients, their squares and the squared sum
  always_comb begin
    logic [9:0] sl, sr, st, sb;
    logic signed [21:0] px, py;
    for (int i = 0; i < 3; i++) begin
      sl = {2'b0, s1_l_r.top[i]} + {1'b0, s1_l_r.mid[i], 1'b0} + {2'b0, s1_l_r.bot[i]};
      sr = {2'b0, s1_r_r.top[i]} + {1'b0, s1_r_r.mid[i], 1'b0} + {2'b0, s1_r_r.bot[i]};
      st = {2'b0, s1_l_r.top[i]} + {1'b0, s1_c_r.top[i], 1'b0} + {2'b0, s1_r_r.top[i]};
      sb = {2'b0, s1_l_r.bot[i]} + {1'b0, s1_c_r.bot[i], 1'b0} + {2'b0, s1_r_r.bot[i]};
      gx[i] = $signed({1'b0, sr}) - $signed({1'b0, sl});
      gy[i] = $signed({1'b0, st}) - $signed({1'b0, sb});
    end
    for (int i = 0; i < 3; i++) begin
      px = s2_gx_r[i] * s2_gx_r[i];
      py = s2_gy_r[i] * s2_gy_r[i];
      sq[2*i]   = px[19:0];
      sq[2*i+1] = py[19:0];
    end
    total = 23'(s3_sq_r[0]) + 23'(s3_sq_r[1]) + 23'(s3_sq_r[2])
          + 23'(s3_sq_r[3]) + 23'(s3_sq_r[4]) + 23'(s3_sq_r[5]);
  end

  always_ff @(posedge clk) begin
    if (issue && s1_rdy) begin
      s1_l_r    <= win_l;
      s1_c_r    <= win_c;
      s1_r_r    <= win_r;
      s1_a_r    <= win_c.mid[3];
      s1_row_r  <= rsel ? j_row_r : j_row_r - ROW_W'(1);
      s1_col_r  <= csel ? j_col_r : j_col_r - COL_W'(1);
      s1_last_r <= j_last;
    end
    if (rdy1) begin
      s2_gx_r   <= gx;
      s2_gy_r   <= gy;
      s2_a_r    <= s1_a_r;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
      s2_last_r <= s1_last_r;
    end
    if (rdy2) begin
      s3_sq_r   <= sq;
      s3_a_r    <= s2_a_r;
      s3_row_r  <= s2_row_r;
      s3_col_r  <= s2_col_r;
      s3_last_r <= s2_last_r;
    end
    if (rdy3) begin
      o_edge_r <= (total > {7'b0, thr_sq_r});
      o_a_r    <= s3_a_r;
      o_row_r  <= s3_row_r;
      o_col_r  <= s3_col_r;
      o_last_r <= s3_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, o_col_r, o_row_r, o_a_r, o_edge_r};
  assign out_tlast  = o_last_r;

`ifndef ASSERT_OFF
  a_job_index : assert property (@(posedge clk) disable iff (!rst_n)
    (j_v_r && !j_empty) |-> ((j_k_r[1] <= (j_ha_r && j_hb_r)) &&
                             (j_k_r[0] <= (j_ca_r && j_cb_r))))
    else $error("job result index past its count");
  a_ready_free : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!j_v_r || j_retire))
    else $error("pixel taken while job still has results");
  a_counters : assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < w_eff) && ({1'b0, row_r} < h_eff))
    else $error("pixel counter outside frame");
  a_issue_slot : assert property (@(posedge clk) disable iff (!rst_n)
    (issue && s1_rdy) |=> s1_v_r)
    else $error("issued window lost");
`endif

endmodule

`default_nettype wire

@@ rtl/sobel_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sobel_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ dv/sobel_edge_threshold_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_threshold_test
// Streams RGBA frames of several geometries and thresholds through the
// Sobel edge block and checks every result transaction against a software
// copy of the line store, the border replication and the squared-gradient
// threshold test.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_test;
  import sobel_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic        is_edge;
    logic [7:0]  alpha;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } edge_result_t;

  class edge_scoreboard;
    logic [31:0]  lines [3][MAX_WIDTH];
    int unsigned  col_cnt, row_cnt, width_reg, height_reg, thresh_reg;
    edge_result_t pending_q[$];
    int           errors;

    function new();
      col_cnt = 0; row_cnt = 0;
      width_reg = 1024; height_reg = 1024; thresh_reg = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_WIDTH: begin
          width_reg = val[WCFG_W-1:0]; col_cnt = 0; row_cnt = 0;
        end
        REG_HEIGHT: begin
          height_reg = val[HCFG_W-1:0]; col_cnt = 0; row_cnt = 0;
        end
        REG_THRESH: thresh_reg = val[7:0];
        default: ;
      endcase
    endfunction

    function int clip(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    function logic edge_at(int i, int j, int w, int h);
      int total, gx, gy, y, x, v;
      total = 0;
      for (int ch = 0; ch < 3; ch++) begin
        gx = 0; gy = 0;
        for (int dy = 0; dy < 3; dy++) begin
          y = clip(i + dy - 1, h - 1);
          for (int dx = 0; dx < 3; dx++) begin
            x = clip(j + dx - 1, w - 1);
            v = (lines[y % 3][x] >> (8 * ch)) & 8'hFF;
            gx += (dx - 1) * (dy == 1 ? 2 : 1) * v;
            gy += (1 - dy) * (dx == 1 ? 2 : 1) * v;
          end
        end
        total += gx * gx + gy * gy;
      end
      return total > thresh_reg * thresh_reg;
    endfunction

    function void note_pixel(logic [31:0] pix);
      int w, h, r, c, nr, nc;
      int rows[2], cols[2];
      edge_result_t e;
      w = width_reg < 1 ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
      h = height_reg < 1 ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
      r = row_cnt >= h ? h - 1 : row_cnt;
      c = col_cnt >= w ? w - 1 : col_cnt;
      lines[r % 3][c] = pix;
      nr = 0; nc = 0;
      if (r >= 1) rows[nr++] = r - 1;
      if (r == h - 1) rows[nr++] = r;
      if (c >= 1) cols[nc++] = c - 1;
      if (c == w - 1) cols[nc++] = c;
      for (int a = 0; a < nr; a++) begin
        for (int b = 0; b < nc; b++) begin
          e.is_edge = edge_at(rows[a], cols[b], w, h);
          e.alpha   = lines[rows[a] % 3][cols[b]][31:24];
          e.row     = rows[a];
          e.col     = cols[b];
          e.last    = (a == nr - 1) && (b == nc - 1);
          pending_q.push_back(e);
        end
      end
      c++;
      if (c >= w) begin
        c = 0; r++;
        if (r >= h) r = 0;
      end
      col_cnt = c; row_cnt = r;
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
    endtask

    task check_result(logic [31:0] d, logic last);
      edge_result_t e;
      if (pending_q.size() == 0) begin
        report("unexpected transaction, data", d, 0);
        return;
      end
      e = pending_q.pop_front();
      if (d[0] !== e.is_edge) report("is_edge", d[0], e.is_edge);
      if (d[8:1] !== e.alpha) report("pixel_alpha", d[8:1], e.alpha);
      if (d[20:9] !== e.row) report("out_row", d[20:9], e.row);
      if (d[30:21] !== e.col) report("out_column", d[30:21], e.col);
      if (last !== e.last) report("out_tlast", last, e.last);
    endtask
  endclass

  logic             clk, rst_n;
  logic             in_tvalid, in_tready;
  logic [31:0]      in_tdata;
  logic             out_tvalid, out_tready, out_tlast;
  logic [31:0]      out_tdata;
  logic             cfg_we;
  logic [1:0]       cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  edge_scoreboard sb;
  bit             stall_on;
  int             sent;

  sobel_edge_threshold uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    out_tready <= stall_on ? ($urandom_range(99) >= 37) : 1'b1;
  end

  task automatic send_pixel(logic [31:0] pix);
    while (stall_on && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(pix);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic send_frame(int w, int h, int flavor);
    logic [31:0] base;
    base = $urandom;
    for (int k = 0; k < w * h; k++) begin
      case (flavor)
        0: send_pixel($urandom);
        1: send_pixel(base ^ ($urandom & 32'h0303_0303));
        default: send_pixel(($urandom_range(1) ? 32'h00FF_FFFF : 32'h0) | ($urandom << 24));
      endcase
      if (k == w + 1 && $urandom_range(3) == 0) drain();
    end
  endtask

  initial begin
    int w, h;
    sb = new();
    rst_n = 0; in_tvalid = 0; in_tdata = 0; out_tready = 0;
    cfg_we = 0; cfg_addr = REG_WIDTH; cfg_wdata = 0;
    stall_on = 0; sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: first row only, no results
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);
    write_cfg(REG_WIDTH, 4);
    write_cfg(REG_HEIGHT, 3);
    write_cfg(REG_THRESH, 0);
    for (int k = 0; k < 12; k++) send_pixel(k[0] ? 32'hFFFF_FFFF : 32'h0000_0000);
    write_cfg(REG_THRESH, 255);
    for (int k = 0; k < 12; k++) send_pixel((k % 4 < 2) ? 32'h80FF_FFFF : 32'h7F00_0000);
    write_cfg(REG_UNUSED, 13'h1FFF);
    write_cfg(REG_WIDTH, 0);
    write_cfg(REG_HEIGHT, 0);
    send_pixel(32'hA5A5_A5A5);
    send_pixel(32'h5A5A_5A5A);
    write_cfg(REG_WIDTH, 13'h07FF);
    write_cfg(REG_HEIGHT, 1);
    for (int k = 0; k < 3; k++) send_pixel($urandom);
    write_cfg(REG_WIDTH, 3);
    write_cfg(REG_HEIGHT, 13'h1FFF);
    for (int k = 0; k < 6; k++) send_pixel($urandom);
    write_cfg(REG_THRESH, 128);
    for (int k = 0; k < 3; k++) send_pixel($urandom);

    while (sent < 300) begin
      stall_on = sent > 130;
      w = $urandom_range(3) == 0 ? 1 : $urandom_range(9, 1);
      h = $urandom_range(3) == 0 ? 1 : $urandom_range(6, 1);
      write_cfg(REG_WIDTH, w);
      write_cfg(REG_HEIGHT, h);
      case ($urandom_range(3))
        0: write_cfg(REG_THRESH, 0);
        1: write_cfg(REG_THRESH, 255);
        default: write_cfg(REG_THRESH, $urandom_range(255));
      endcase
      send_frame(w, h, $urandom_range(2));
      if ($urandom_range(1)) send_frame(w, h, $urandom_range(2));
      for (int k = $urandom_range(2); k > 0; k--) send_pixel($urandom);
    end

    drain();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
